>>> hw/rtl/osb_pkg.sv
`timescale 1ns / 1ps

package osb_pkg;

    // Bank size and derived widths.
    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = 16;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_CREATE    = 3'd1,
        REQ_CHG_PER   = 3'd2,
        REQ_QRY_PER   = 3'd3,
        REQ_CONTROL   = 3'd4,
        REQ_GET_STATE = 3'd5,
        REQ_DELETE    = 3'd6,
        REQ_RESET     = 3'd7
    } req_code_t;

    // Result kinds.
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Answers of the get state command.
    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Input item.
    typedef struct packed {
        req_code_t          req_type;
        logic [2:0]         timer_id;
        logic [CNT_W-1:0]   period_in;
        logic               run_flag;
        logic               handler_present;
    } req_t;

    // Result item.
    typedef struct packed {
        logic               result_kind;
        logic [2:0]         entry_index;
        logic               ok;
        logic [CNT_W-1:0]   period_out;
        logic [1:0]         state_code;
        logic               last;
    } rsp_t;

    // One timer entry.
    typedef struct packed {
        logic               allocated;
        logic               running;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   period;
    } entry_t;

    // Write request into the timer bank.
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        entry_t             data;
    } bank_wr_t;

    // States of the sequencer.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_WALK,
        S_FLUSH
    } fsm_state_t;

endpackage

>>> hw/rtl/osb_tick_unit.sv
`timescale 1ns / 1ps

module osb_tick_unit
    import osb_pkg::*;
(
    input  logic [CNT_W-1:0] count,
    input  logic [CNT_W-1:0] period,
    output logic [CNT_W-1:0] next_count,
    output logic             expire
);

    // Shared increment and compare: the count wraps at its width.
    always_comb
    begin
        next_count = count + CNT_W'(1);
        expire     = (next_count >= period);
    end

endmodule

>>> hw/rtl/osb_bank.sv
`timescale 1ns / 1ps

module osb_bank
    import osb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  bank_wr_t         wr
);

    entry_t bank_reg [NUM_TIMERS];

    // Entry storage; reset clears every entry to its power-up value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                bank_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            bank_reg[wr.addr] <= wr.data;
        end
    end

    // Single read port shared by commands and the tick walk.
    assign rd_data = bank_reg[rd_addr];

endmodule

>>> hw/rtl/osb_ctrl.sv
`timescale 1ns / 1ps

module osb_ctrl
    import osb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             result_valid,
    output rsp_t             result,
    output logic [IDX_W-1:0] rd_addr,
    input  entry_t           rd_data,
    output bank_wr_t         wr
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    fsm_state_t       state_reg, state_next;
    req_t             req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic [CNT_W-1:0] next_count;
    logic             expire;
    logic             id_ok;
    logic [IDX_W-1:0] cmd_addr;

    osb_tick_unit u_tick (
        .count      (rd_data.count),
        .period     (rd_data.period),
        .next_count (next_count),
        .expire     (expire)
    );

    assign id_ok    = (32'(req_reg.timer_id) < NUM_TIMERS);
    assign cmd_addr = IDX_W'(req_reg.timer_id);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.req_type == REQ_TICK) ? S_WALK : S_CMD;
                end
            end
            S_CMD:   state_next = S_IDLE;
            S_WALK:  state_next = (idx_reg == LAST_IDX) ? S_FLUSH : S_WALK;
            S_FLUSH: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs of each state.
    always_comb
    begin
        busy           = (state_reg != S_IDLE);
        req_next       = req_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        rd_addr        = (state_reg == S_WALK) ? idx_reg : cmd_addr;
        wr.en          = 1'b0;
        wr.addr        = rd_addr;
        wr.data        = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = req;
                    idx_next  = '0;
                    pend_next = 1'b0;
                end
            end

            S_CMD:
            begin
                out_next.result_kind = KIND_REPLY;
                out_next.entry_index = req_reg.timer_id;
                out_next.ok          = 1'b1;
                out_next.period_out  = '0;
                out_next.state_code  = ST_STOPPED;
                out_next.last        = 1'b1;
                out_valid_next       = 1'b1;
                if (!id_ok)
                begin
                    out_next.ok = 1'b0;
                    if (req_reg.req_type == REQ_GET_STATE)
                    begin
                        out_next.state_code = ST_INVALID;
                    end
                end
                else
                begin
                    unique case (req_reg.req_type)
                        REQ_CREATE:
                        begin
                            wr.en             = 1'b1;
                            wr.data.allocated = req_reg.handler_present;
                            wr.data.running   = req_reg.run_flag;
                            wr.data.count     = '0;
                            wr.data.period    = req_reg.period_in;
                        end
                        REQ_CHG_PER:
                        begin
                            wr.en          = 1'b1;
                            wr.data.period = req_reg.period_in;
                        end
                        REQ_QRY_PER:
                        begin
                            out_next.period_out = rd_data.period;
                        end
                        REQ_CONTROL:
                        begin
                            if (rd_data.allocated)
                            begin
                                wr.en           = 1'b1;
                                wr.data.running = req_reg.run_flag;
                            end
                            else
                            begin
                                out_next.ok = 1'b0;
                            end
                        end
                        REQ_GET_STATE:
                        begin
                            if (rd_data.allocated)
                            begin
                                out_next.state_code =
                                    rd_data.running ? ST_RUNNING : ST_STOPPED;
                            end
                            else
                            begin
                                out_next.ok         = 1'b0;
                                out_next.state_code = ST_INVALID;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (rd_data.allocated)
                            begin
                                wr.en             = 1'b1;
                                wr.data.allocated = 1'b0;
                                wr.data.running   = 1'b0;
                                wr.data.count     = '0;
                            end
                            else
                            begin
                                out_next.ok = 1'b0;
                            end
                        end
                        REQ_RESET:
                        begin
                            if (rd_data.allocated)
                            begin
                                wr.en           = 1'b1;
                                wr.data.running = req_reg.run_flag;
                                wr.data.count   = '0;
                            end
                            else
                            begin
                                out_next.ok = 1'b0;
                            end
                        end
                        REQ_TICK:
                        begin
                            // A tick never reaches this state.
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // One entry per cycle; an expiry is held back one find so the
                // final one of the walk can be marked as last.
                idx_next = idx_reg + IDX_W'(1);
                if (rd_data.allocated && rd_data.running)
                begin
                    wr.en         = 1'b1;
                    wr.data.count = next_count;
                    if (expire)
                    begin
                        wr.data.running = 1'b0;
                        if (pend_reg)
                        begin
                            out_valid_next       = 1'b1;
                            out_next.result_kind = KIND_EXPIRY;
                            out_next.entry_index = 3'(pend_idx_reg);
                            out_next.ok          = 1'b1;
                            out_next.period_out  = '0;
                            out_next.state_code  = ST_STOPPED;
                            out_next.last        = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_idx_next = idx_reg;
                    end
                end
            end

            S_FLUSH:
            begin
                // Release the held expiry, if any, as the final result.
                if (pend_reg)
                begin
                    out_valid_next       = 1'b1;
                    out_next.result_kind = KIND_EXPIRY;
                    out_next.entry_index = 3'(pend_idx_reg);
                    out_next.ok          = 1'b1;
                    out_next.period_out  = '0;
                    out_next.state_code  = ST_STOPPED;
                    out_next.last        = 1'b1;
                end
                pend_next = 1'b0;
            end

            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> hw/rtl/one_shot_timer_bank_top.sv
`timescale 1ns / 1ps

// Bank of NUM_TIMERS one-shot timers. A request transfers at a rising edge
// where start is high and busy is low. A command reads and updates one entry,
// and its single reply shows on result with result_valid high for one cycle,
// in the cycle in which busy drops. During a tick a shared increment-and-compare
// unit visits one entry per cycle through a single bank port. Expiry events
// come out one per cycle at most while the walk runs, each strobed for exactly
// one cycle; the final one carries last. A tick with no expiry gives no
// result. The receiver cannot stall: every strobed result must be taken in
// the cycle it is shown.
module one_shot_timer_bank_top
    import osb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic result_valid,
    output rsp_t result
);

    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    bank_wr_t         wr;

    // Sequencer with the shared tick unit.
    osb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr           (wr)
    );

    // Timer entry storage.
    osb_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

endmodule

>>> hw/rtl/osb_checker.sv
`timescale 1ns / 1ps

module osb_checker
    import osb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic result_valid,
    input rsp_t result
);

    // A command transfer gives its reply, marked last, once the command state has passed.
    a_cmd_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type != REQ_TICK) |-> ##2
        (result_valid && result.last && result.result_kind == KIND_REPLY))
        else $error("command reply missing or malformed");

    // A command reply is always the only result of its request.
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == KIND_REPLY) |-> result.last)
        else $error("command reply without last");

    // An expiry event carries no period and no state answer.
    a_expiry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == KIND_EXPIRY) |->
        (result.ok && result.period_out == '0 && result.state_code == ST_STOPPED))
        else $error("expiry event with stray fields");

    // The final result of a request shows once the block is free again.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final result shown while busy");

endmodule

bind one_shot_timer_bank_top osb_checker u_osb_checker (.*);
